@@ hdl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the depletion rate estimator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DRE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/dre_pkg.sv @@
// Types, constants and codes shared by the depletion rate estimator files.
`timescale 1ns / 1ps

package dre_pkg;

    // Field widths of the channels.
    localparam int AMOUNT_FIELD_BITS = 48;
    localparam int US_BITS           = 32;
    localparam int RATE_BITS         = 56;
    localparam int SECS_BITS         = 32;
    localparam int W_BITS            = 17;
    localparam int CFG_INDEX_BITS    = 2;
    localparam int CFG_DATA_BITS     = 56;

    // Default width of the stored amount.
    localparam int DEF_AMOUNT_BITS = 48;

    // Arithmetic constants.
    localparam int SCALE_BITS  = 20;
    localparam int BLEND_SHIFT = 16;
    localparam int BLEND_PROD_BITS = RATE_BITS + W_BITS + 1;
    localparam logic [SCALE_BITS-1:0] MICROS_PER_SEC  = 20'd1000000;
    localparam logic [US_BITS-1:0]    MIN_INTERVAL_US = 32'd100000;
    localparam logic [W_BITS-1:0]     ONE_Q16         = 17'd65536;
    localparam logic [W_BITS-1:0]     SMOOTHING_RESET = 17'd32768;
    localparam logic [RATE_BITS-1:0]  RATE_MAX        = '1;
    localparam logic [SECS_BITS-1:0]  SECS_MAX        = '1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_RATE  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SMOOTHING = 2'd1;

    // Input opcodes.
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // One input beat.
    typedef struct packed {
        logic                         opcode;
        logic [AMOUNT_FIELD_BITS-1:0] remaining;
        logic [US_BITS-1:0]           elapsed_us;
    } sample_t;

    // One result beat.
    typedef struct packed {
        logic                         rate_usable;
        logic [RATE_BITS-1:0]         rate_q8;
        logic                         depletion_valid;
        logic [SECS_BITS-1:0]         seconds_left;
        logic [AMOUNT_FIELD_BITS-1:0] last_amount;
    } result_t;

    // Status of a serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_RATE,
        ST_DIV_RATE,
        ST_MUL_BLEND,
        ST_FINISH,
        ST_DIV_SECS,
        ST_OUTPUT
    } state_t;

endpackage

@@ hdl/depletion_rate_estimator.sv @@
// Top level of the depletion rate estimator: sequencer, state and result register.
//
//  Channel  | Handshake           | Payload
//  ---------+---------------------+---------------------------------------
//  sample   | sample_valid/stall  | sample   (opcode, remaining, elapsed_us)
//  result   | result_valid/stall  | result   (usable, rate, seconds, amount)
//  cfg      | cfg_valid/ready     | cfg_index, cfg_data
//
// A restart, a first sample or a sample under 0.1 s goes from the idle state straight
// to the finish and output states, by way of the (AMOUNT_BITS+8)-step seconds divide
// when a usable rate is stored. A sample that blends a rate runs a 20-step multiply,
// an (AMOUNT_BITS+28)-step divide, a 20-step blend multiply and, with a usable rate,
// the seconds divide; one that seeds the average skips the blend multiply. All of
// them share one multiplier and one divider.
// One item is in work at a time; the result register holds a beat while the next
// item is taken. Reset is asynchronous and needs no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module depletion_rate_estimator #(
    parameter int AMOUNT_BITS = dre_pkg::DEF_AMOUNT_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  sample_valid,
    output logic                                  sample_stall,
    input  dre_pkg::sample_t                      sample,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output dre_pkg::result_t                      result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dre_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [dre_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int RB     = dre_pkg::RATE_BITS;
    localparam int DIV_NW = AMOUNT_BITS + dre_pkg::SCALE_BITS + 8;
    localparam int DIV_SW = $clog2(DIV_NW + 1);
    localparam int MUL_W  = (AMOUNT_BITS + dre_pkg::SCALE_BITS > dre_pkg::BLEND_PROD_BITS) ?
                            AMOUNT_BITS + dre_pkg::SCALE_BITS : dre_pkg::BLEND_PROD_BITS;
    localparam int QX     = (DIV_NW > RB + 1) ? DIV_NW : RB + 1;

    // Sequencer and architectural state.
    dre_pkg::state_t                  state_reg, state_next;
    logic                             have_last_reg, have_last_next;
    logic [AMOUNT_BITS-1:0]           last_value_reg, last_value_next;
    logic                             rate_known_reg, rate_known_next;
    logic [RB-1:0]                    smoothed_reg, smoothed_next;
    logic [RB-1:0]                    min_rate_reg, min_rate_next;
    logic [dre_pkg::W_BITS-1:0]       smoothing_reg, smoothing_next;
    logic [dre_pkg::US_BITS-1:0]      us_reg, us_next;
    logic                             usable_reg, usable_next;
    logic                             dep_reg, dep_next;
    logic [dre_pkg::SECS_BITS-1:0]    secs_reg, secs_next;
    logic                             result_valid_reg, result_valid_next;
    dre_pkg::result_t                 result_reg, result_next;

    // Sequencer outputs.
    logic accept;
    logic long_path;
    logic mul_start, mul_blend;
    logic div_start, div_secs;
    logic out_load;

    // Datapath signals.
    logic [AMOUNT_BITS-1:0]           amount;
    logic [AMOUNT_BITS-1:0]           drop;
    logic [dre_pkg::W_BITS-1:0]       w_eff;
    logic signed [RB:0]               rate_diff;
    logic [MUL_W-1:0]                 mul_mcand;
    logic [dre_pkg::SCALE_BITS-1:0]   mul_mplier;
    logic [MUL_W-1:0]                 mul_prod;
    logic signed [MUL_W-1:0]          blend_shifted;
    dre_pkg::unit_stat_t              mul_stat;
    logic [DIV_NW-1:0]                div_num;
    logic [RB-1:0]                    div_den;
    logic [DIV_SW-1:0]                div_steps;
    logic [DIV_NW-1:0]                div_quo;
    logic [QX-1:0]                    div_quo_ext;
    dre_pkg::unit_stat_t              div_stat;
    logic [RB-1:0]                    rate_sat;
    logic [dre_pkg::SECS_BITS-1:0]    secs_sat;
    logic                             usable_c;
    logic [63:0]                      last_ext;

    // Input decode.
    assign amount    = AMOUNT_BITS'(64'(sample.remaining));
    assign long_path = (sample.opcode == dre_pkg::OP_SAMPLE) && have_last_reg &&
                       (sample.elapsed_us >= dre_pkg::MIN_INTERVAL_US);
    assign drop      = (last_value_reg > amount) ? last_value_reg - amount : '0;
    assign w_eff     = (smoothing_reg > dre_pkg::ONE_Q16) ? dre_pkg::ONE_Q16 : smoothing_reg;

    // Saturated results of the divider.
    assign div_quo_ext = QX'(div_quo);
    assign rate_sat    = (div_quo_ext > QX'(dre_pkg::RATE_MAX)) ?
                         dre_pkg::RATE_MAX : div_quo_ext[RB-1:0];
    assign secs_sat    = (div_quo_ext > QX'(dre_pkg::SECS_MAX)) ?
                         dre_pkg::SECS_MAX : div_quo_ext[dre_pkg::SECS_BITS-1:0];

    // Blend: new = old + floor(w * (rate - old) / 65536).
    assign rate_diff     = $signed({1'b0, rate_sat}) - $signed({1'b0, smoothed_reg});
    assign blend_shifted = $signed(mul_prod) >>> dre_pkg::BLEND_SHIFT;

    // Rate usability from the stored state.
    assign usable_c = rate_known_reg && (smoothed_reg != '0) && (smoothed_reg >= min_rate_reg);

    // Shared multiplier operands.
    assign mul_mcand  = mul_blend ? MUL_W'(rate_diff) : MUL_W'(drop);
    assign mul_mplier = mul_blend ? dre_pkg::SCALE_BITS'(w_eff) : dre_pkg::MICROS_PER_SEC;

    // Shared divider operands.
    assign div_num   = div_secs ? {last_value_reg, 8'b0, dre_pkg::SCALE_BITS'(0)} :
                                  {mul_prod[AMOUNT_BITS+dre_pkg::SCALE_BITS-1:0], 8'b0};
    assign div_den   = div_secs ? smoothed_reg : RB'(us_reg);
    assign div_steps = div_secs ? DIV_SW'(AMOUNT_BITS + 8) : DIV_SW'(DIV_NW);

    dre_mul #(
        .MW (MUL_W),
        .PW (dre_pkg::SCALE_BITS)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .mcand  (mul_mcand),
        .mplier (mul_mplier),
        .stat   (mul_stat),
        .prod   (mul_prod)
    );

    dre_div #(
        .NW (DIV_NW),
        .DW (RB)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .steps (div_steps),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dre_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = long_path ? dre_pkg::ST_MUL_RATE : dre_pkg::ST_FINISH;
                end
            end
            dre_pkg::ST_MUL_RATE:
            begin
                if (mul_stat.done)
                begin
                    state_next = dre_pkg::ST_DIV_RATE;
                end
            end
            dre_pkg::ST_DIV_RATE:
            begin
                if (div_stat.done)
                begin
                    state_next = rate_known_reg ? dre_pkg::ST_MUL_BLEND : dre_pkg::ST_FINISH;
                end
            end
            dre_pkg::ST_MUL_BLEND:
            begin
                if (mul_stat.done)
                begin
                    state_next = dre_pkg::ST_FINISH;
                end
            end
            dre_pkg::ST_FINISH:
            begin
                state_next = (usable_c && have_last_reg) ? dre_pkg::ST_DIV_SECS :
                                                           dre_pkg::ST_OUTPUT;
            end
            dre_pkg::ST_DIV_SECS:
            begin
                if (div_stat.done)
                begin
                    state_next = dre_pkg::ST_OUTPUT;
                end
            end
            dre_pkg::ST_OUTPUT:
            begin
                if (out_load)
                begin
                    state_next = dre_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dre_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: handshakes and unit starts.
    always_comb
    begin
        sample_stall = 1'b1;
        mul_start    = 1'b0;
        mul_blend    = 1'b0;
        div_start    = 1'b0;
        div_secs     = 1'b0;
        out_load     = 1'b0;
        unique case (state_reg)
            dre_pkg::ST_IDLE:
            begin
                sample_stall = 1'b0;
                mul_start    = sample_valid && long_path;
            end
            dre_pkg::ST_MUL_RATE:
            begin
                div_start = mul_stat.done;
            end
            dre_pkg::ST_DIV_RATE:
            begin
                mul_blend = 1'b1;
                mul_start = div_stat.done && rate_known_reg;
            end
            dre_pkg::ST_MUL_BLEND:
            begin
                mul_blend = 1'b1;
            end
            dre_pkg::ST_FINISH:
            begin
                div_secs  = 1'b1;
                div_start = usable_c && have_last_reg;
            end
            dre_pkg::ST_DIV_SECS:
            begin
                div_secs = 1'b1;
            end
            dre_pkg::ST_OUTPUT:
            begin
                out_load = !result_valid_reg || !result_stall;
            end
            default:
            begin
                sample_stall = 1'b1;
            end
        endcase
    end

    assign accept = sample_valid && !sample_stall;

    // Next values of the state, configuration and result registers.
    always_comb
    begin
        have_last_next    = have_last_reg;
        last_value_next   = last_value_reg;
        rate_known_next   = rate_known_reg;
        smoothed_next     = smoothed_reg;
        min_rate_next     = min_rate_reg;
        smoothing_next    = smoothing_reg;
        us_next           = us_reg;
        usable_next       = usable_reg;
        dep_next          = dep_reg;
        secs_next         = secs_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        last_ext          = 64'(last_value_reg);

        // Configuration writes.
        if (cfg_valid)
        begin
            unique case (cfg_index)
                dre_pkg::CFG_MIN_RATE:  min_rate_next  = cfg_data[RB-1:0];
                dre_pkg::CFG_SMOOTHING: smoothing_next = cfg_data[dre_pkg::W_BITS-1:0];
                default:                min_rate_next  = min_rate_reg;
            endcase
        end

        // Item entry.
        if (accept)
        begin
            if (sample.opcode == dre_pkg::OP_RESTART)
            begin
                have_last_next  = 1'b0;
                last_value_next = '0;
                rate_known_next = 1'b0;
                smoothed_next   = '0;
            end
            else if (!have_last_reg)
            begin
                have_last_next  = 1'b1;
                last_value_next = amount;
            end
            else if (long_path)
            begin
                last_value_next = amount;
                us_next         = sample.elapsed_us;
            end
        end

        // First rate seeds the average.
        if (state_reg == dre_pkg::ST_DIV_RATE && div_stat.done && !rate_known_reg)
        begin
            smoothed_next   = rate_sat;
            rate_known_next = 1'b1;
        end

        // Later rates blend into it.
        if (state_reg == dre_pkg::ST_MUL_BLEND && mul_stat.done)
        begin
            smoothed_next = smoothed_reg + blend_shifted[RB-1:0];
        end

        // Flags of the result.
        if (state_reg == dre_pkg::ST_FINISH)
        begin
            usable_next = usable_c;
            dep_next    = usable_c && have_last_reg;
            secs_next   = '0;
        end

        if (state_reg == dre_pkg::ST_DIV_SECS && div_stat.done)
        begin
            secs_next = secs_sat;
        end

        // Result register: load a new beat or drop the taken one.
        if (out_load)
        begin
            result_valid_next           = 1'b1;
            result_next.rate_usable     = usable_reg;
            result_next.rate_q8         = rate_known_reg ? smoothed_reg : '0;
            result_next.depletion_valid = dep_reg;
            result_next.seconds_left    = secs_reg;
            result_next.last_amount     = have_last_reg ?
                                          last_ext[dre_pkg::AMOUNT_FIELD_BITS-1:0] : '0;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= dre_pkg::ST_IDLE;
            have_last_reg    <= 1'b0;
            last_value_reg   <= '0;
            rate_known_reg   <= 1'b0;
            smoothed_reg     <= '0;
            min_rate_reg     <= '0;
            smoothing_reg    <= dre_pkg::SMOOTHING_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            have_last_reg    <= have_last_next;
            last_value_reg   <= last_value_next;
            rate_known_reg   <= rate_known_next;
            smoothed_reg     <= smoothed_next;
            min_rate_reg     <= min_rate_next;
            smoothing_reg    <= smoothing_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        us_reg     <= us_next;
        usable_reg <= usable_next;
        dep_reg    <= dep_next;
        secs_reg   <= secs_next;
        result_reg <= result_next;
    end

    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Without a rate the average stays cleared.
    `DRE_ASSERT_IMPLY(a_no_rate_zero, clk, rst_n, !rate_known_reg, smoothed_reg == '0, "smoothed rate set without a known rate")
    // Without a stored amount the amount stays cleared.
    `DRE_ASSERT_IMPLY(a_no_last_zero, clk, rst_n, !have_last_reg, last_value_reg == '0, "amount held without a sample")
    // Both arithmetic units are quiet while waiting for an item.
    `DRE_ASSERT_IMPLY(a_idle_quiet, clk, rst_n, state_reg == dre_pkg::ST_IDLE, !mul_stat.busy && !div_stat.busy, "arithmetic unit busy while idle")
    // A free result register is filled in the cycle after the output state.
    `DRE_ASSERT_NEXT(a_out_fill, clk, rst_n, (state_reg == dre_pkg::ST_OUTPUT) && !result_valid_reg, result_valid_reg && (state_reg == dre_pkg::ST_IDLE), "result not loaded")

endmodule

@@ hdl/dre_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module dre_mul #(
    parameter int MW = 74,
    parameter int PW = 20
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MW-1:0]      mcand,
    input  logic [PW-1:0]      mplier,
    output dre_pkg::unit_stat_t stat,
    output logic [MW-1:0]      prod
);

    localparam int CW = $clog2(PW + 1);

    logic [MW-1:0] acc_reg, acc_next;
    logic [MW-1:0] mcand_reg, mcand_next;
    logic [PW-1:0] mplier_reg, mplier_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    // Load on start, then add the shifted multiplicand for each set multiplier bit.
    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            acc_next    = '0;
            mcand_next  = mcand;
            mplier_next = mplier;
            cnt_next    = CW'(PW);
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[MW-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[PW-1:1]};
            cnt_next    = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Operand and accumulator registers.
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = acc_reg;

endmodule

@@ hdl/dre_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module dre_div #(
    parameter int NW = 76,
    parameter int DW = 56
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [NW-1:0]            num,
    input  logic [DW-1:0]            den,
    input  logic [$clog2(NW+1)-1:0]  steps,
    output dre_pkg::unit_stat_t      stat,
    output logic [NW-1:0]            quo
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg, num_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [DW:0]   rem_shift;
    logic [DW:0]   rem_diff;
    logic          fits;

    // Shift the next dividend bit into the remainder and try a subtraction.
    assign rem_shift = {rem_reg, num_reg[NW-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign fits      = rem_shift >= {1'b0, den_reg};

    // The quotient bits enter the dividend register from the bottom.
    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
            num_next = {num_reg[NW-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Dividend, remainder and divisor registers.
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = num_reg;

endmodule

@@ tb/depletion_rate_estimator_tb.sv @@
// Self-checking testbench of the depletion rate estimator with its own rate predictor.
`timescale 1ns / 1ps

module depletion_rate_estimator_tb;
    import dre_pkg::*;

    // Cycles with no beat on any channel before the run is declared hung.
    localparam int QUIET_LIMIT   = 20000;
    // Cycles to let pass once the last result is in.
    localparam int DRAIN_CYCLES  = 300;
    localparam int IDLE_PERCENT  = 21;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      sample_valid = 1'b0;
    logic                      sample_stall;
    sample_t                   sample       = '0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    result_t                   result;
    logic                      cfg_valid    = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;

    // When set, neither side idles nor stalls.
    bit calm = 1'b0;

    sample_t sample_backlog[$];
    result_t estimate_q[$];
    int      mismatch_count = 0;
    int      result_count   = 0;
    int      quiet_cycles   = 0;

    // Predictor copy of the registers and of the estimator state.
    logic [RATE_BITS-1:0]         model_min_rate = '0;
    logic [W_BITS-1:0]            model_weight   = SMOOTHING_RESET;
    logic                         model_have_last = 1'b0;
    logic [AMOUNT_FIELD_BITS-1:0] model_last      = '0;
    logic                         model_rate_known = 1'b0;
    logic [RATE_BITS-1:0]         model_rate      = '0;

    depletion_rate_estimator #(
        .AMOUNT_BITS(DEF_AMOUNT_BITS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock, 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input logic [63:0] seen,
                                   input logic [63:0] wanted);
        $display("result %0d %s: got 0x%0h, want 0x%0h", result_count, what, seen, wanted);
        mismatch_count++;
    endtask

    // Advances the predicted estimator state by one input beat and forms its result.
    task automatic advance_estimator(input sample_t beat, output result_t est);
        logic [AMOUNT_FIELD_BITS-1:0] drop;
        logic [95:0]                  wide_rate;
        logic [RATE_BITS-1:0]         new_rate;
        logic [W_BITS-1:0]            weight;
        logic [79:0]                  mix;
        logic [63:0]                  secs;
        logic                         usable;
        if (beat.opcode == OP_RESTART)
        begin
            model_have_last  = 1'b0;
            model_last       = '0;
            model_rate_known = 1'b0;
            model_rate       = '0;
        end
        else if (!model_have_last)
        begin
            // The first sample only stores its amount.
            model_have_last = 1'b1;
            model_last      = beat.remaining;
        end
        else if (beat.elapsed_us >= MIN_INTERVAL_US)
        begin
            // Rate in Q8 units per second, zero for a rising amount, saturated.
            drop = (model_last > beat.remaining) ? model_last - beat.remaining : '0;
            wide_rate = (96'(drop) * 96'd256000000) / 96'(beat.elapsed_us);
            new_rate = (wide_rate > 96'(RATE_MAX)) ? RATE_MAX : wide_rate[RATE_BITS-1:0];
            weight = (model_weight > ONE_Q16) ? ONE_Q16 : model_weight;
            if (!model_rate_known)
            begin
                model_rate       = new_rate;
                model_rate_known = 1'b1;
            end
            else
            begin
                mix = (80'(weight) * 80'(new_rate)
                       + 80'(W_BITS'(ONE_Q16 - weight)) * 80'(model_rate)) >> BLEND_SHIFT;
                model_rate = mix[RATE_BITS-1:0];
            end
            model_last = beat.remaining;
        end

        usable = model_rate_known && (model_rate != '0) && (model_rate >= model_min_rate);
        est = '0;
        est.rate_usable     = usable;
        est.rate_q8         = model_rate_known ? model_rate : '0;
        est.depletion_valid = usable && model_have_last;
        if (est.depletion_valid)
        begin
            secs = (64'(model_last) << 8) / 64'(model_rate);
            est.seconds_left = (secs > 64'(SECS_MAX)) ? SECS_MAX : secs[SECS_BITS-1:0];
        end
        est.last_amount = model_have_last ? model_last : '0;
    endtask

    // Input driver: holds a stalled beat, otherwise takes the next pending one or idles.
    always @(posedge clk)
    begin
        result_t est;
        logic    idle;
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
            begin
                advance_estimator(sample, est);
                estimate_q.push_back(est);
            end
            if (!(sample_valid && sample_stall))
            begin
                idle = !calm && ($urandom_range(99) < IDLE_PERCENT);
                if (sample_backlog.size() > 0 && !idle)
                begin
                    sample       <= sample_backlog.pop_front();
                    sample_valid <= 1'b1;
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each accepted beat with the oldest estimate.
    always @(posedge clk)
    begin
        result_t wanted;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (estimate_q.size() == 0)
                begin
                    report_mismatch("unexpected beat, last_amount", 64'(result.last_amount),
                                    64'd0);
                end
                else
                begin
                    wanted = estimate_q.pop_front();
                    if (result.rate_usable !== wanted.rate_usable)
                        report_mismatch("rate_usable", 64'(result.rate_usable),
                                        64'(wanted.rate_usable));
                    if (result.rate_q8 !== wanted.rate_q8)
                        report_mismatch("rate_q8", 64'(result.rate_q8), 64'(wanted.rate_q8));
                    if (result.depletion_valid !== wanted.depletion_valid)
                        report_mismatch("depletion_valid", 64'(result.depletion_valid),
                                        64'(wanted.depletion_valid));
                    if (result.seconds_left !== wanted.seconds_left)
                        report_mismatch("seconds_left", 64'(result.seconds_left),
                                        64'(wanted.seconds_left));
                    if (result.last_amount !== wanted.last_amount)
                        report_mismatch("last_amount", 64'(result.last_amount),
                                        64'(wanted.last_amount));
                end
                result_count++;
            end
            result_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Watchdog on cycles in which no channel moves a beat.
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("depletion_rate_estimator: mismatch");
            $finish;
        end
    end

    function automatic sample_t make_beat(input logic op,
                                          input logic [AMOUNT_FIELD_BITS-1:0] amount,
                                          input logic [US_BITS-1:0] us);
        sample_t beat;
        beat.opcode     = op;
        beat.remaining  = amount;
        beat.elapsed_us = us;
        return beat;
    endfunction

    function automatic logic [AMOUNT_FIELD_BITS-1:0] random_amount();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[AMOUNT_FIELD_BITS-1:0];
    endfunction

    // Writes one register and mirrors it in the predictor once the beat is taken.
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                  input logic [CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == CFG_MIN_RATE)
            model_min_rate = data[RATE_BITS-1:0];
        else
            model_weight = data[W_BITS-1:0];
    endtask

    // Waits until every pending beat went in and every estimate came back.
    task automatic wait_drained();
        while (sample_backlog.size() > 0 || sample_valid || estimate_q.size() > 0)
            @(posedge clk);
    endtask

    // Edges of the fields and every special case, under the reset register values.
    task automatic queue_directed_items();
        sample_backlog.push_back(make_beat(OP_RESTART, '1, '1));
        // First sample is stored even with no timing.
        sample_backlog.push_back(make_beat(OP_SAMPLE, '1, '0));
        // Too soon after the previous sample: ignored.
        sample_backlog.push_back(make_beat(OP_SAMPLE, '0, 32'd99999));
        // Full drop at the shortest interval saturates the rate.
        sample_backlog.push_back(make_beat(OP_SAMPLE, '0, MIN_INTERVAL_US));
        sample_backlog.push_back(make_beat(OP_SAMPLE, '0, '1));
        // A growing amount gives a zero rate.
        sample_backlog.push_back(make_beat(OP_SAMPLE, 48'd1000, 32'd200000));
        sample_backlog.push_back(make_beat(OP_SAMPLE, '0, MIN_INTERVAL_US));
        sample_backlog.push_back(make_beat(OP_RESTART, '0, '0));
        // Small rate against a large amount saturates the seconds.
        sample_backlog.push_back(make_beat(OP_SAMPLE, 48'h8000_0000_0000, '1));
        sample_backlog.push_back(make_beat(OP_SAMPLE, 48'h7FFF_FFFF_FFFF, 32'd1000000));
        sample_backlog.push_back(make_beat(OP_SAMPLE, 48'h7FFF_FFFF_0000, 32'd1000000));
        sample_backlog.push_back(make_beat(OP_SAMPLE, 48'd1, MIN_INTERVAL_US));
        sample_backlog.push_back(make_beat(OP_SAMPLE, '0, 32'd150000));
        sample_backlog.push_back(make_beat(OP_RESTART, 48'h5555_5555_5555, 32'hAAAA_AAAA));
    endtask

    // Mostly draining sequences with random drops and intervals, plus restarts and noise.
    task automatic queue_random_items(input int count);
        logic [AMOUNT_FIELD_BITS-1:0] level;
        logic [AMOUNT_FIELD_BITS-1:0] step_amt;
        logic [US_BITS-1:0]           gap_us;
        int                           pick;
        int                           shape;
        level = random_amount();
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
            begin
                sample_backlog.push_back(make_beat(OP_RESTART, random_amount(), $urandom));
            end
            else if (pick < 10)
            begin
                level = random_amount();
                sample_backlog.push_back(make_beat(OP_SAMPLE, level, $urandom));
            end
            else if (pick < 18)
            begin
                sample_backlog.push_back(make_beat(OP_SAMPLE, level, $urandom_range(0, 99999)));
            end
            else
            begin
                step_amt = random_amount() >> $urandom_range(0, AMOUNT_FIELD_BITS - 1);
                shape = $urandom_range(9);
                if (shape == 0)
                    level = level + step_amt;
                else if (shape > 1)
                    level = (step_amt > level) ? '0 : level - step_amt;
                shape = $urandom_range(9);
                if (shape == 0)
                    gap_us = MIN_INTERVAL_US;
                else if (shape == 1)
                    gap_us = $urandom;
                else
                    gap_us = $urandom_range(100000, 20000000);
                sample_backlog.push_back(make_beat(OP_SAMPLE, level, gap_us));
            end
        end
    endtask

    // One setting of both registers followed by a random stretch of items.
    task automatic run_phase(input logic [RATE_BITS-1:0] min_rate,
                             input logic [W_BITS-1:0] weight, input int count,
                             input bit no_gaps);
        logic [63:0] filler;
        wait_drained();
        repeat (8) @(posedge clk);
        write_register(CFG_MIN_RATE, min_rate);
        // Bits above the weight field are random and must have no effect.
        filler = {$urandom, $urandom};
        write_register(CFG_SMOOTHING, {filler[CFG_DATA_BITS-1:W_BITS], weight});
        calm <= no_gaps;
        queue_random_items(count);
        wait_drained();
    endtask

    function automatic logic [RATE_BITS-1:0] random_rate();
        logic [63:0] raw;
        raw = {$urandom, $urandom} >> $urandom_range(0, 63);
        return raw[RATE_BITS-1:0];
    endfunction

    // Stimulus sequence and end of run.
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        queue_directed_items();
        wait_drained();

        run_phase('0, ONE_Q16, 110, 1'b1);
        run_phase(RATE_MAX, '0, 100, 1'b0);
        run_phase(RATE_BITS'($urandom_range(1, 100000)), '1, 100, 1'b0);
        run_phase(RATE_BITS'(2560000), W_BITS'(1), 100, 1'b0);
        repeat (3)
            run_phase(random_rate(), W_BITS'($urandom_range(0, 131071)), 80, 1'b0);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && estimate_q.size() == 0)
            $display("depletion_rate_estimator: match");
        else
            $display("depletion_rate_estimator: mismatch");
        $finish;
    end

endmodule
